FILE: src/flash_command_sequencer_macros.svh
// Assertion helpers for the flash command sequencer.
// All checks sample on the rising edge of clk and are off while rst_n is low.
`ifndef FLASH_COMMAND_SEQUENCER_MACROS_SVH
`define FLASH_COMMAND_SEQUENCER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define FCS_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed: label");

// Next-cycle implication
`define FCS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: label");

`else

`define FCS_ASSERT_IMPL(label, pre, post)
`define FCS_ASSERT_NEXT(label, pre, post)

`endif

`endif

FILE: src/fcs_pkg.sv
`timescale 1ns / 1ps

package fcs_pkg;

    // Block numbering limits
    localparam int MAX_BLOCK_COUNT = 35;
    localparam int BLK_W           = 6;
    localparam int BOOT_W          = 5;

    // Store geometry
    localparam int MADDR_W = 22;
    localparam int MLEN_W  = 17;

    // Unlock and command bytes
    localparam logic [15:0] UNLOCK_ADDR1 = 16'h5555;
    localparam logic [15:0] UNLOCK_ADDR2 = 16'h2AAA;
    localparam logic [7:0]  UNLOCK_DATA1 = 8'hAA;
    localparam logic [7:0]  UNLOCK_DATA2 = 8'h55;
    localparam logic [7:0]  CMD_BYTE_ERASE_SETUP = 8'h80;
    localparam logic [7:0]  CMD_BYTE_ID          = 8'h90;
    localparam logic [7:0]  CMD_BYTE_PROGRAM     = 8'hA0;
    localparam logic [7:0]  CMD_BYTE_RESET       = 8'hF0;
    localparam logic [7:0]  CMD_BYTE_BLOCK_ERASE = 8'h30;
    localparam logic [7:0]  CMD_BYTE_BLOCK_ERASE_ALT = 8'h50;
    localparam logic [7:0]  CMD_BYTE_CHIP_ERASE  = 8'h10;
    localparam logic [7:0]  MANUFACTURER_ID      = 8'h98;
    localparam logic [7:0]  ID_LAST_BYTE         = 8'h80;
    localparam logic [7:0]  ERASE_FILL           = 8'hFF;

    // Write cycle positions in the unlock sequence
    localparam logic [2:0] WC_FIRST   = 3'd1;
    localparam logic [2:0] WC_SECOND  = 3'd2;
    localparam logic [2:0] WC_COMMAND = 3'd3;
    localparam logic [2:0] WC_FOURTH  = 3'd4;
    localparam logic [2:0] WC_FIFTH   = 3'd5;
    localparam logic [2:0] WC_SIXTH   = 3'd6;

    // Input kinds carried on the slave tuser
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_INFO  = 1'b1;

    // Configuration register index
    localparam logic REG_CART_SIZE = 1'b0;

    // Cartridge size codes
    localparam logic [2:0] SIZE_NONE   = 3'd0;
    localparam logic [2:0] SIZE_4M     = 3'd1;
    localparam logic [2:0] SIZE_8M     = 3'd2;
    localparam logic [2:0] SIZE_16M    = 3'd3;
    localparam logic [2:0] SIZE_DUAL   = 3'd4;

    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_INFO   = 3'd1,
        CMD_PROG   = 3'd2,
        CMD_BERASE = 3'd3,
        CMD_CERASE = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        MEMOP_NONE  = 2'd0,
        MEMOP_PROG  = 2'd1,
        MEMOP_ERASE = 2'd2
    } memop_t;

    // Result of one block lookup
    typedef struct packed {
        logic [BLK_W-1:0]   blk;
        logic [MADDR_W-1:0] start;
        logic [MLEN_W-1:0]  len;
    } blk_info_t;

    // Clamp unused size codes to the two-chip setting
    function automatic logic [2:0] size_sel(input logic [2:0] code);
        size_sel = (code > SIZE_DUAL) ? SIZE_DUAL : code;
    endfunction

    // First boot block number per size
    function automatic logic [BOOT_W-1:0] boot_num(input logic [2:0] code);
        logic [BOOT_W-1:0] bn;
        unique case (size_sel(code))
            SIZE_NONE: bn = 5'd0;
            SIZE_4M:   bn = 5'd7;
            SIZE_8M:   bn = 5'd15;
            default:   bn = 5'd31;
        endcase
        return bn;
    endfunction

    // ID byte by address low bits
    function automatic logic [7:0] id_byte(input logic [2:0] code, input logic [1:0] sel);
        logic [2:0] sz;
        logic [7:0] dev;
        logic [7:0] b;
        sz = size_sel(code);
        unique case (sz)
            SIZE_NONE: dev = 8'h00;
            SIZE_4M:   dev = 8'hAB;
            SIZE_8M:   dev = 8'h2C;
            default:   dev = 8'h2F;
        endcase
        unique case (sel)
            2'd0:    b = (sz == SIZE_NONE) ? 8'h00 : MANUFACTURER_ID;
            2'd1:    b = dev;
            2'd2:    b = 8'h00;
            default: b = ID_LAST_BYTE;
        endcase
        return b;
    endfunction

endpackage

FILE: src/fcs_block_map.sv
`timescale 1ns / 1ps

// Map a chip-local address to its block number, and that block to its
// start address and length under the boot-block layout 32K/8K/8K/16K.
module fcs_block_map
    import fcs_pkg::*;
(
    input  logic [BOOT_W-1:0] boot,
    input  logic              chip,
    input  logic [20:0]       addr,
    output blk_info_t         info
);

    logic [BLK_W-1:0] blk;
    logic [BLK_W-1:0] k;
    logic [20:0]      local_start;

    // Find the block holding the address
    always_comb
    begin
        if (addr[20:16] == boot)
        begin
            priority if (addr[15:0] < 16'h8000)
                blk = {1'b0, boot};
            else if (addr[15:0] < 16'hA000)
                blk = {1'b0, boot} + 6'd1;
            else if (addr[15:0] < 16'hC000)
                blk = {1'b0, boot} + 6'd2;
            else
                blk = {1'b0, boot} + 6'd3;
        end
        else
        begin
            blk = {1'b0, addr[20:16]};
        end
    end

    // Start and length of that block
    always_comb
    begin
        k           = blk - {1'b0, boot};
        local_start = {blk[4:0], 16'h0000};
        info.len    = 17'h10000;
        if (blk >= {1'b0, boot})
        begin
            priority if (k == 6'd0)
            begin
                local_start = {boot, 16'h0000};
                info.len    = 17'h08000;
            end
            else if (k == 6'd1)
            begin
                local_start = {boot, 16'h8000};
                info.len    = 17'h02000;
            end
            else if (k == 6'd2)
            begin
                local_start = {boot, 16'hA000};
                info.len    = 17'h02000;
            end
            else if (k == 6'd3)
            begin
                local_start = {boot, 16'hC000};
                info.len    = 17'h04000;
            end
            else
            begin
                local_start = {boot, 16'hC000};
                info.len    = 17'h10000;
            end
        end
        info.blk   = blk;
        info.start = {chip, local_start};
    end

endmodule

FILE: src/flash_command_sequencer.sv
`timescale 1ns / 1ps

// Flash command sequencer.
// Slave stream: one cartridge bus access per transfer, tuser = 0 for a flash
// write, 1 for an ID read. The master stream returns exactly one result per
// access: the ID byte, at most one store operation (program byte by AND, or
// erase a block range to 0xFF), the dirtied chip/block, and status flags.
// The access is decoded against the unlock state in the cycle it is taken
// and the result is registered. Throughput is one access per cycle; the only
// loops are the unlock state and save-pending registers, updated in one pass.
// A result that waits in the output register does not stop the next access
// as long as the receiver takes it in the same cycle; with tready low and a
// result held, s_tready drops until it is taken.
// The user must write the cart size register over the APB-style port only
// while the block is idle; the block does not enforce this. The register
// selects the ID bytes and the boot-block position. Reset empties the output
// register, returns the sequence to its first write cycle with no command,
// clears the save-pending flag and sets the size to two chips.
module flash_command_sequencer
    import fcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // access in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // bus_addr[23:0], bus_data[31:24]
    input  logic        s_tuser,   // cmd[0]
    // result out
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0], mem_addr[29:8], mem_len[46:30], mem_data[54:47],
    // dirty_chip[55], dirty_block[61:56], save_request[62],
    // save_pending[63], info_mode[64], zero fill[71:65]
    output logic [71:0] m_tdata,
    output logic [1:0]  m_tuser,   // mem_op[1:0]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "flash_command_sequencer_macros.svh"

    logic [2:0]  size_reg;
    logic [2:0]  wc_reg;
    logic [2:0]  wc_next;
    cmd_t        cmd_reg;
    cmd_t        cmd_next;
    logic        pend_reg;
    logic        pend_next;

    logic        out_valid_reg;
    logic [71:0] out_data_reg;
    memop_t      out_op_reg;

    logic        in_xfer;
    logic        kind;
    logic [23:0] addr;
    logic [7:0]  data;
    logic [15:0] lo;
    logic [23:0] prog_a;
    logic [20:0] lookup_addr;
    logic [BOOT_W-1:0] boot;
    blk_info_t   binfo;
    logic        blk_ok;

    logic [7:0]         rd;
    memop_t             op;
    logic [MADDR_W-1:0] maddr;
    logic [MLEN_W-1:0]  mlen;
    logic [7:0]         mdata;
    logic               chip;
    logic [BLK_W-1:0]   blk;
    logic               save;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = {29'd0, size_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= SIZE_DUAL;
        else if (psel && penable && pwrite && (paddr[2] == REG_CART_SIZE))
            size_reg <= pwdata[2:0];
    end

    // Unpack the access
    assign kind     = s_tuser;
    assign addr     = s_tdata[23:0];
    assign data     = s_tdata[31:24];
    assign lo       = addr[15:0];
    assign s_tready = !out_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;
    assign boot     = boot_num(size_reg);

    // Fold the program windows down onto the store
    always_comb
    begin
        unique case (addr[23:21])
            3'b001:  prog_a = {3'b000, addr[20:0]};
            3'b100:  prog_a = {3'b001, addr[20:0]};
            default: prog_a = addr;
        endcase
    end

    assign lookup_addr = (wc_reg == WC_FOURTH) ? prog_a[20:0] : addr[20:0];

    fcs_block_map u_block_map (
        .boot (boot),
        .chip (addr[23]),
        .addr (lookup_addr),
        .info (binfo)
    );

    assign blk_ok = (binfo.blk != '0) &&
                    ({1'b0, binfo.blk} < (BLK_W + 1)'(MAX_BLOCK_COUNT));

    // Next sequence state and the result of this access
    always_comb
    begin
        wc_next   = wc_reg;
        cmd_next  = cmd_reg;
        pend_next = pend_reg;
        rd        = 8'h00;
        op        = MEMOP_NONE;
        maddr     = '0;
        mlen      = '0;
        mdata     = 8'h00;
        chip      = 1'b0;
        blk       = '0;
        save      = 1'b0;

        if (kind == KIND_INFO)
        begin
            wc_next  = WC_FIRST;
            cmd_next = CMD_INFO;
            rd       = id_byte(size_reg, addr[1:0]);
        end
        else if (addr[23] && (size_sel(size_reg) != SIZE_DUAL))
        begin
            // second-chip window without a second chip: drop the write
        end
        else
        begin
            unique case (wc_reg)
                WC_FIRST:
                begin
                    cmd_next = CMD_NONE;
                    if (lo == UNLOCK_ADDR1 && data == UNLOCK_DATA1)
                        wc_next = WC_SECOND;
                    else
                    begin
                        wc_next = WC_FIRST;
                        save    = (data == CMD_BYTE_RESET);
                    end
                end
                WC_SECOND, WC_FIFTH:
                begin
                    cmd_next = CMD_NONE;
                    wc_next  = (lo == UNLOCK_ADDR2 && data == UNLOCK_DATA2) ?
                               wc_reg + 3'd1 : WC_FIRST;
                end
                WC_COMMAND:
                begin
                    cmd_next = CMD_NONE;
                    wc_next  = WC_FIRST;
                    if (lo == UNLOCK_ADDR1)
                    begin
                        priority if (data == CMD_BYTE_ERASE_SETUP)
                            wc_next = WC_FOURTH;
                        else if (data == CMD_BYTE_RESET)
                            save = 1'b1;
                        else if (data == CMD_BYTE_ID)
                        begin
                            wc_next  = WC_FOURTH;
                            cmd_next = CMD_INFO;
                        end
                        else if (data == CMD_BYTE_PROGRAM)
                        begin
                            wc_next  = WC_FOURTH;
                            cmd_next = CMD_PROG;
                        end
                        else
                            wc_next = WC_FIRST;
                    end
                end
                WC_FOURTH:
                begin
                    cmd_next = CMD_NONE;
                    if (cmd_reg == CMD_PROG)
                    begin
                        wc_next = WC_FIRST;
                        if (blk_ok && prog_a[23:22] == 2'b00)
                        begin
                            op    = MEMOP_PROG;
                            maddr = prog_a[MADDR_W-1:0];
                            mlen  = 17'd1;
                            mdata = data;
                            chip  = prog_a[21];
                            blk   = binfo.blk;
                        end
                    end
                    else
                    begin
                        wc_next = (lo == UNLOCK_ADDR1 && data == UNLOCK_DATA1) ?
                                  WC_FIFTH : WC_FIRST;
                    end
                end
                WC_SIXTH:
                begin
                    wc_next = WC_FIRST;
                    priority if (lo == UNLOCK_ADDR1 && data == CMD_BYTE_CHIP_ERASE)
                        cmd_next = CMD_CERASE;
                    else if (data == CMD_BYTE_BLOCK_ERASE ||
                             data == CMD_BYTE_BLOCK_ERASE_ALT)
                    begin
                        cmd_next = CMD_BERASE;
                        if (blk_ok)
                        begin
                            op    = MEMOP_ERASE;
                            maddr = binfo.start;
                            mlen  = binfo.len;
                            mdata = ERASE_FILL;
                            chip  = addr[23];
                            blk   = binfo.blk;
                        end
                    end
                    else
                        cmd_next = CMD_NONE;
                end
                default:
                begin
                    wc_next  = WC_FIRST;
                    cmd_next = CMD_NONE;
                end
            endcase
        end

        if (op != MEMOP_NONE)
            pend_next = 1'b1;
    end

    // Advance the sequence on each accepted access
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg   <= WC_FIRST;
            cmd_reg  <= CMD_NONE;
            pend_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            wc_reg   <= wc_next;
            cmd_reg  <= cmd_next;
            pend_reg <= pend_next;
        end
    end

    // Output register: load on an accepted access, drop after transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_xfer)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_op_reg   <= op;
            out_data_reg <= {7'd0, (cmd_next == CMD_INFO), pend_next, save, blk, chip,
                             mdata, mlen, maddr, rd};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_op_reg;

    // Checks
    `FCS_ASSERT_IMPL(a_op_sets_pending, m_tvalid && (m_tuser != MEMOP_NONE), m_tdata[63])
    `FCS_ASSERT_NEXT(a_info_read_mode, in_xfer && (kind == KIND_INFO), m_tvalid && m_tdata[64])
    `FCS_ASSERT_NEXT(a_pending_sticky, pend_reg, pend_reg)
    `FCS_ASSERT_IMPL(a_ready_when_empty, !out_valid_reg, s_tready)

endmodule

FILE: dv/flash_command_sequencer_checker.sv
`timescale 1ns / 1ps

module flash_command_sequencer_checker
    import fcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // bus_addr[23:0], bus_data[31:24]
    input  logic        s_tuser,   // cmd[0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0], mem_addr[29:8], mem_len[46:30], mem_data[54:47],
    // dirty_chip[55], dirty_block[61:56], save_request[62],
    // save_pending[63], info_mode[64], zero fill[71:65]
    input  logic [71:0] m_tdata,
    input  logic [1:0]  m_tuser,   // mem_op[1:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          error_count,
    output int          outstanding,
    output int          program_count,
    output int          erase_count,
    output int          id_read_count,
    output int          save_request_count
);

    localparam logic [2:0] CART_SIZE_ADDR = 3'(4 * int'(REG_CART_SIZE));

    localparam logic [7:0] DEVICE_ID_4M  = 8'hAB;
    localparam logic [7:0] DEVICE_ID_8M  = 8'h2C;
    localparam logic [7:0] DEVICE_ID_16M = 8'h2F;

    typedef struct packed {
        logic [7:0]  read_data;
        memop_t      op;
        logic [21:0] addr;
        logic [16:0] len;
        logic [7:0]  fill;
        logic        chip;
        logic [5:0]  blk;
        logic        save_request;
        logic        save_pending;
        logic        info_mode;
    } op_result_t;

    // Command machine state, mirrored from the bus traffic
    logic [2:0] write_cycle;
    cmd_t       current_cmd;
    logic       pending_save;
    logic [2:0] cart_size;

    op_result_t sequencer_results_q[$];
    op_result_t seen;
    op_result_t due;

    // First boot block of the chip for a size code
    function automatic logic [4:0] boot_block(input logic [2:0] code);
        case (code)
            SIZE_NONE: return 5'd0;
            SIZE_4M:   return 5'd7;
            SIZE_8M:   return 5'd15;
            default:   return 5'd31;
        endcase
    endfunction

    // Block number inside one chip; the boot area splits into 32K/8K/8K/16K
    function automatic logic [5:0] block_index(input logic [4:0] boot, input logic [23:0] addr);
        logic [20:0] a;
        logic [20:0] base;
        logic [20:0] off;
        a = addr[20:0];
        base = {boot, 16'h0000};
        off = a - base;
        if (a >= base && off < 21'h08000)
            return 6'(boot);
        if (a >= base && off < 21'h0A000)
            return 6'(boot) + 6'd1;
        if (a >= base && off < 21'h0C000)
            return 6'(boot) + 6'd2;
        if (a >= base && off < 21'h10000)
            return 6'(boot) + 6'd3;
        return {1'b0, a[20:16]};
    endfunction

    function automatic logic [21:0] block_base(input logic chip, input logic [4:0] boot,
                                               input logic [5:0] blk);
        logic [21:0] a;
        logic [5:0]  k;
        if (blk >= 6'(boot))
        begin
            k = blk - 6'(boot);
            a = {1'b0, boot, 16'h0000};
            if (k >= 6'd1)
                a += 22'h08000;
            if (k >= 6'd2)
                a += 22'h02000;
            if (k >= 6'd3)
                a += 22'h02000;
        end
        else
            a = {blk, 16'h0000};
        if (chip)
            a += 22'h200000;
        return a;
    endfunction

    function automatic logic [16:0] block_bytes(input logic [4:0] boot, input logic [5:0] blk);
        logic [5:0] k;
        if (blk >= 6'(boot))
        begin
            k = blk - 6'(boot);
            if (k == 6'd0)
                return 17'h08000;
            if (k == 6'd1 || k == 6'd2)
                return 17'h02000;
            if (k == 6'd3)
                return 17'h04000;
        end
        return 17'h10000;
    endfunction

    function automatic logic [7:0] id_value(input logic [2:0] code, input logic [1:0] sel);
        case (sel)
            2'd0:    return (code == SIZE_NONE) ? 8'h00 : MANUFACTURER_ID;
            2'd1:
            begin
                case (code)
                    SIZE_NONE: return 8'h00;
                    SIZE_4M:   return DEVICE_ID_4M;
                    SIZE_8M:   return DEVICE_ID_8M;
                    default:   return DEVICE_ID_16M;
                endcase
            end
            2'd2:    return 8'h00;
            default: return ID_LAST_BYTE;
        endcase
    endfunction

    // Advance the unlock/command machine by one bus access and build its result
    task automatic run_command_machine(input logic kind, input logic [23:0] addr,
                                       input logic [7:0] data, output op_result_t r);
        logic [15:0] lo;
        logic [4:0]  boot;
        logic [23:0] a;
        logic [5:0]  blk;
        logic        chip;
        logic        dual;
        r = '0;
        lo = addr[15:0];
        boot = boot_block(cart_size);
        dual = (cart_size >= SIZE_DUAL);
        blk = '0;
        chip = 1'b0;
        if (kind == KIND_INFO)
        begin
            write_cycle = WC_FIRST;
            current_cmd = CMD_INFO;
            r.read_data = id_value(cart_size, addr[1:0]);
        end
        else if (addr >= 24'h800000 && !dual)
        begin
            // second-chip window on a one-chip cart: drop the write
        end
        else
        begin
            case (write_cycle)
                WC_FIRST:
                begin
                    if (lo == UNLOCK_ADDR1 && data == UNLOCK_DATA1)
                        write_cycle = WC_SECOND;
                    else
                    begin
                        write_cycle = WC_FIRST;
                        if (data == CMD_BYTE_RESET)
                            r.save_request = 1'b1;
                    end
                    current_cmd = CMD_NONE;
                end
                WC_SECOND, WC_FIFTH:
                begin
                    write_cycle = (lo == UNLOCK_ADDR2 && data == UNLOCK_DATA2) ?
                                  write_cycle + 3'd1 : WC_FIRST;
                    current_cmd = CMD_NONE;
                end
                WC_COMMAND:
                begin
                    current_cmd = CMD_NONE;
                    write_cycle = WC_FIRST;
                    if (lo == UNLOCK_ADDR1)
                    begin
                        if (data == CMD_BYTE_ERASE_SETUP)
                            write_cycle = WC_FOURTH;
                        else if (data == CMD_BYTE_RESET)
                            r.save_request = 1'b1;
                        else if (data == CMD_BYTE_ID)
                        begin
                            write_cycle = WC_FOURTH;
                            current_cmd = CMD_INFO;
                        end
                        else if (data == CMD_BYTE_PROGRAM)
                        begin
                            write_cycle = WC_FOURTH;
                            current_cmd = CMD_PROG;
                        end
                    end
                end
                WC_FOURTH:
                begin
                    if (current_cmd == CMD_PROG)
                    begin
                        // fold both chip windows onto the store address
                        a = addr;
                        if (a >= 24'h200000 && a < 24'h400000)
                            a -= 24'h200000;
                        else if (a >= 24'h800000 && a < 24'hA00000)
                            a -= 24'h600000;
                        blk = block_index(boot, a);
                        if (blk != 6'd0 && a < 24'h400000 && blk < MAX_BLOCK_COUNT)
                        begin
                            r.op = MEMOP_PROG;
                            r.addr = a[21:0];
                            r.len = 17'd1;
                            r.fill = data;
                            chip = (a >= 24'h200000);
                        end
                        write_cycle = WC_FIRST;
                    end
                    else
                        write_cycle = (lo == UNLOCK_ADDR1 && data == UNLOCK_DATA1) ?
                                      WC_FIFTH : WC_FIRST;
                    current_cmd = CMD_NONE;
                end
                WC_SIXTH:
                begin
                    write_cycle = WC_FIRST;
                    if (lo == UNLOCK_ADDR1 && data == CMD_BYTE_CHIP_ERASE)
                        current_cmd = CMD_CERASE;
                    else if (data == CMD_BYTE_BLOCK_ERASE || data == CMD_BYTE_BLOCK_ERASE_ALT)
                    begin
                        current_cmd = CMD_BERASE;
                        chip = (addr >= 24'h800000);
                        blk = block_index(boot, addr);
                        if (blk != 6'd0 && blk < MAX_BLOCK_COUNT)
                        begin
                            r.op = MEMOP_ERASE;
                            r.addr = block_base(chip, boot, blk);
                            r.len = block_bytes(boot, blk);
                            r.fill = ERASE_FILL;
                        end
                    end
                    else
                        current_cmd = CMD_NONE;
                end
                default:
                begin
                    write_cycle = WC_FIRST;
                    current_cmd = CMD_NONE;
                end
            endcase
        end
        // chip and block are only reported alongside an operation
        if (r.op != MEMOP_NONE)
        begin
            pending_save = 1'b1;
            r.chip = chip;
            r.blk = blk;
        end
        r.save_pending = pending_save;
        r.info_mode = (current_cmd == CMD_INFO);
    endtask

    function automatic int check_field(input string name, input longint unsigned want,
                                       input longint unsigned got);
        if (want == got)
            return 0;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        return 1;
    endfunction

    // Track register writes, compare each result transfer, then queue the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_cycle = WC_FIRST;
            current_cmd = CMD_NONE;
            pending_save = 1'b0;
            cart_size = SIZE_DUAL;
            sequencer_results_q.delete();
            error_count = 0;
            outstanding = 0;
            program_count = 0;
            erase_count = 0;
            id_read_count = 0;
            save_request_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == CART_SIZE_ADDR)
                cart_size = pwdata[2:0];

            if (m_tvalid && m_tready)
            begin
                seen.read_data = m_tdata[7:0];
                seen.op = memop_t'(m_tuser);
                seen.addr = m_tdata[29:8];
                seen.len = m_tdata[46:30];
                seen.fill = m_tdata[54:47];
                seen.chip = m_tdata[55];
                seen.blk = m_tdata[61:56];
                seen.save_request = m_tdata[62];
                seen.save_pending = m_tdata[63];
                seen.info_mode = m_tdata[64];
                if (sequencer_results_q.size() == 0)
                begin
                    $display("%0t: result with none outstanding, expected nothing, actual 0x%0h",
                             $time, seen);
                    error_count++;
                end
                else
                begin
                    due = sequencer_results_q.pop_front();
                    error_count += check_field("read_data", due.read_data, seen.read_data);
                    error_count += check_field("mem_op", due.op, seen.op);
                    error_count += check_field("mem_addr", due.addr, seen.addr);
                    error_count += check_field("mem_len", due.len, seen.len);
                    error_count += check_field("mem_data", due.fill, seen.fill);
                    error_count += check_field("dirty_chip", due.chip, seen.chip);
                    error_count += check_field("dirty_block", due.blk, seen.blk);
                    error_count += check_field("save_request", due.save_request,
                                               seen.save_request);
                    error_count += check_field("save_pending", due.save_pending,
                                               seen.save_pending);
                    error_count += check_field("info_mode", due.info_mode, seen.info_mode);
                end
            end

            if (s_tvalid && s_tready)
            begin
                run_command_machine(s_tuser, s_tdata[23:0], s_tdata[31:24], due);
                sequencer_results_q.push_back(due);
                if (s_tuser == KIND_INFO)
                    id_read_count++;
                if (due.op == MEMOP_PROG)
                    program_count++;
                if (due.op == MEMOP_ERASE)
                    erase_count++;
                if (due.save_request)
                    save_request_count++;
            end

            outstanding = sequencer_results_q.size();
        end
    end

endmodule

FILE: dv/flash_command_sequencer_tb.sv
`timescale 1ns / 1ps

module flash_command_sequencer_tb;
    import fcs_pkg::*;

    localparam logic [2:0] CART_SIZE_ADDR = 3'(4 * int'(REG_CART_SIZE));

    // Size codes above the two-chip setting, which act as two chips
    localparam logic [2:0] SIZE_SPARE_LO  = 3'd5;
    localparam logic [2:0] SIZE_SPARE_MID = 3'd6;
    localparam logic [2:0] SIZE_SPARE_HI  = 3'd7;

    localparam int PHASE_COUNT = 9;
    localparam int PHASE_ITEMS = 125;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // bus_addr[23:0], bus_data[31:24]
    logic        s_tuser;   // cmd[0]
    logic        m_tvalid;
    logic        m_tready;
    // read_data[7:0], mem_addr[29:8], mem_len[46:30], mem_data[54:47],
    // dirty_chip[55], dirty_block[61:56], save_request[62],
    // save_pending[63], info_mode[64], zero fill[71:65]
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;   // mem_op[1:0]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int error_count;
    int outstanding;
    int program_count;
    int erase_count;
    int id_read_count;
    int save_request_count;

    int         accepted_items;
    int         tx_gap_odds;
    int         rx_stall_odds;
    bit         quiet_tail;
    logic [2:0] cart_size;

    flash_command_sequencer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    flash_command_sequencer_checker sequencer_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .s_tvalid           (s_tvalid),
        .s_tready           (s_tready),
        .s_tdata            (s_tdata),
        .s_tuser            (s_tuser),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .m_tdata            (m_tdata),
        .m_tuser            (m_tuser),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .pready             (pready),
        .error_count        (error_count),
        .outstanding        (outstanding),
        .program_count      (program_count),
        .erase_count        (erase_count),
        .id_read_count      (id_read_count),
        .save_request_count (save_request_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the handshakes hang
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", outstanding);
        $display("RESULT: ERROR");
        $finish;
    end

    // Drive the receiver ready with random stall bursts
    initial
    begin
        int beats;
        beats = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            beats++;
            if (beats % 64 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       rx_stall_odds = 0;
                    1:       rx_stall_odds = 4;
                    default: rx_stall_odds = 16;
                endcase
            end
            if (!quiet_tail && rx_stall_odds != 0 && $urandom_range(1, rx_stall_odds) == 1)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Present one bus access and hold it until the transfer; starts and ends on a falling edge
    task automatic send_access(input logic kind, input logic [23:0] addr, input logic [7:0] data);
        if (accepted_items % 40 == 0)
        begin
            case ($urandom_range(0, 2))
                0:       tx_gap_odds = 0;
                1:       tx_gap_odds = 3;
                default: tx_gap_odds = 12;
            endcase
        end
        if (!quiet_tail && tx_gap_odds != 0 && $urandom_range(1, tx_gap_odds) == 1)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {data, addr};
        do
            @(posedge clk);
        while (!s_tready);
        // writes to the second-chip window of a one-chip cart do nothing
        if (!(kind == KIND_WRITE && addr >= 24'h800000 && cart_size < SIZE_DUAL))
            accepted_items++;
        @(negedge clk);
    endtask

    // Walk the first steps of the erase unlock sequence: AA, 55, 80, AA, 55
    task automatic send_erase_prefix(input logic [7:0] page, input int steps);
        for (int i = 0; i < steps; i++)
        begin
            case (i)
                0:       send_access(KIND_WRITE, {page, UNLOCK_ADDR1}, UNLOCK_DATA1);
                1:       send_access(KIND_WRITE, {page, UNLOCK_ADDR2}, UNLOCK_DATA2);
                2:       send_access(KIND_WRITE, {page, UNLOCK_ADDR1}, CMD_BYTE_ERASE_SETUP);
                3:       send_access(KIND_WRITE, {page, UNLOCK_ADDR1}, UNLOCK_DATA1);
                default: send_access(KIND_WRITE, {page, UNLOCK_ADDR2}, UNLOCK_DATA2);
            endcase
        end
    endtask

    // Hold until every result has come back
    task automatic wait_idle();
        while (outstanding != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic cart_write(input logic [2:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CART_SIZE_ADDR;
        pwdata <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        cart_size = value;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Pick a target spread over both chip windows, the boot area and block zero
    function automatic logic [23:0] random_target();
        logic [20:0] boot_base;
        logic [2:0]  window;
        case (cart_size)
            SIZE_NONE: boot_base = 21'h000000;
            SIZE_4M:   boot_base = 21'h070000;
            SIZE_8M:   boot_base = 21'h0F0000;
            default:   boot_base = 21'h1F0000;
        endcase
        case ($urandom_range(0, 2))
            0:       window = 3'b000;
            1:       window = 3'b001;
            default: window = 3'b100;
        endcase
        case ($urandom_range(0, 5))
            0:       return 24'($urandom);
            1:       return {3'b000, 21'($urandom)};
            2:       return {3'b001, 21'($urandom)};
            3:       return {3'b100, 21'($urandom)};
            4:       return {window, boot_base + 21'($urandom_range(0, 16'hFFFF))};
            default: return {window, 5'd0, 16'($urandom)};
        endcase
    endfunction

    initial
    begin
        logic [2:0] phase_sizes [0:PHASE_COUNT-1];
        logic [7:0] page;
        logic [7:0] erase_byte;
        int         pick;
        int         steps;
        int         phase_end;

        phase_sizes = '{SIZE_NONE, SIZE_4M, SIZE_8M, SIZE_16M, SIZE_SPARE_LO,
                        SIZE_SPARE_HI, SIZE_DUAL, SIZE_SPARE_MID, SIZE_DUAL};
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_WRITE;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        accepted_items = 0;
        tx_gap_odds = 0;
        rx_stall_odds = 0;
        quiet_tail = 1'b0;
        cart_size = SIZE_DUAL;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: ID bytes, reset command, program, top boot block erase on chip 1,
        // chip erase and the ID command, all at the reset size of two chips
        send_access(KIND_INFO, 24'h000000, 8'h00);
        send_access(KIND_INFO, 24'h000001, 8'hFF);
        send_access(KIND_INFO, 24'hFFFFFE, 8'h00);
        send_access(KIND_INFO, 24'hFFFFFF, 8'hFF);
        send_access(KIND_WRITE, 24'h000000, CMD_BYTE_RESET);
        send_erase_prefix(8'h00, 2);
        send_access(KIND_WRITE, {8'h00, UNLOCK_ADDR1}, CMD_BYTE_PROGRAM);
        send_access(KIND_WRITE, 24'h210000, 8'h00);
        send_erase_prefix(8'h80, 5);
        send_access(KIND_WRITE, 24'hFFC000, CMD_BYTE_BLOCK_ERASE);
        send_erase_prefix(8'h00, 5);
        send_access(KIND_WRITE, {8'h00, UNLOCK_ADDR1}, CMD_BYTE_CHIP_ERASE);
        send_erase_prefix(8'h00, 2);
        send_access(KIND_WRITE, {8'h00, UNLOCK_ADDR1}, CMD_BYTE_ID);
        send_access(KIND_INFO, 24'h000003, 8'h00);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            // Resize only with the block idle
            s_tvalid <= 1'b0;
            wait_idle();
            cart_write(phase_sizes[p]);
            if (p == PHASE_COUNT - 1)
            begin
                quiet_tail = 1'b1;
                tx_gap_odds = 0;
            end
            phase_end = accepted_items + PHASE_ITEMS;
            while (accepted_items < phase_end)
            begin
                pick = $urandom_range(0, 99);
                page = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
                erase_byte = $urandom_range(0, 1) ? CMD_BYTE_BLOCK_ERASE
                                                  : CMD_BYTE_BLOCK_ERASE_ALT;
                if (pick < 12)
                    send_access(KIND_INFO, 24'($urandom), 8'($urandom));
                else if (pick < 32)
                begin
                    send_erase_prefix(page, 2);
                    send_access(KIND_WRITE, {page, UNLOCK_ADDR1}, CMD_BYTE_PROGRAM);
                    send_access(KIND_WRITE, random_target(), 8'($urandom));
                end
                else if (pick < 50)
                begin
                    send_erase_prefix(page, 5);
                    send_access(KIND_WRITE, random_target(), erase_byte);
                end
                else if (pick < 58)
                begin
                    send_erase_prefix(page, 5);
                    if ($urandom_range(0, 3) == 0)
                        send_access(KIND_WRITE, random_target(), CMD_BYTE_CHIP_ERASE);
                    else
                        send_access(KIND_WRITE, {page, UNLOCK_ADDR1}, CMD_BYTE_CHIP_ERASE);
                end
                else if (pick < 66)
                begin
                    send_erase_prefix(page, 2);
                    send_access(KIND_WRITE, {page, UNLOCK_ADDR1}, CMD_BYTE_ID);
                    if ($urandom_range(0, 1))
                        send_access(KIND_INFO, 24'($urandom), 8'($urandom));
                    else
                        send_access(KIND_WRITE, random_target(), 8'($urandom));
                end
                else if (pick < 74)
                begin
                    if ($urandom_range(0, 1))
                        send_access(KIND_WRITE, random_target(), CMD_BYTE_RESET);
                    else
                    begin
                        send_erase_prefix(page, 2);
                        send_access(KIND_WRITE, {page, UNLOCK_ADDR1}, CMD_BYTE_RESET);
                    end
                end
                else if (pick < 88)
                begin
                    // Break a sequence partway with a stray access
                    steps = $urandom_range(1, 5);
                    send_erase_prefix(page, steps);
                    case ($urandom_range(0, 3))
                        0:       send_access(KIND_INFO, 24'($urandom), 8'($urandom));
                        1:       send_access(KIND_WRITE, {page, UNLOCK_ADDR1}, 8'($urandom));
                        2:       send_access(KIND_WRITE, {page, UNLOCK_ADDR2}, 8'($urandom));
                        default: send_access(KIND_WRITE, 24'($urandom), 8'($urandom));
                    endcase
                end
                else
                begin
                    if ($urandom_range(0, 1))
                        send_access(KIND_WRITE, {8'($urandom), UNLOCK_ADDR1}, 8'($urandom));
                    else
                        send_access(KIND_WRITE, 24'($urandom), 8'($urandom));
                end
            end
        end

        // Drain and let the output register settle
        s_tvalid <= 1'b0;
        wait_idle();
        repeat (4) @(posedge clk);

        $display("Covered %0d bus accesses over %0d cart size settings.",
                 accepted_items, PHASE_COUNT + 1);
        $display("Saw %0d programs, %0d block erases, %0d ID reads, %0d save requests.",
                 program_count, erase_count, id_read_count, save_request_count);
        if (error_count == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/fcs_pkg.sv
src/fcs_block_map.sv
src/flash_command_sequencer.sv
dv/flash_command_sequencer_checker.sv
dv/flash_command_sequencer_tb.sv
